FILE: hdl/nlp_pkg.sv
// types and constants shared by the next lexicographic permutation core
// no dependencies

package nlp_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic [POS_W-1:0]         position;
        logic                     found;
        logic                     final_res;
    } res_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             found;
        logic             last;
        logic [POS_W-1:0] position;
    } emit_t;

    typedef struct packed {
        logic                     we;
        logic [POS_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic                     re;
        logic [POS_W-1:0]         raddr;
    } mem_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_FIRST,
        S_SCAN,
        S_FIND,
        S_SWAP,
        S_REV_LO,
        S_REV_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_EMIT
    } seq_state_t;

endpackage

FILE: hdl/nlp_mem.sv
// element store: one write port, one read port, registered read data
// depends on nlp_pkg

module nlp_mem #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  nlp_pkg::mem_req_t                req,
    output logic signed [nlp_pkg::DATA_W-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [nlp_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [nlp_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/nlp_seq.sv
// sequencer: commands, pivot scan, swap, suffix reversal and emit beats
// depends on nlp_pkg; drives the nlp_mem request port

module nlp_seq #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  nlp_pkg::cmd_t                      cmd,
    output logic                               busy,
    input  logic signed [nlp_pkg::DATA_W-1:0]  rdata,
    output nlp_pkg::mem_req_t                  mem_req,
    output nlp_pkg::emit_t                     emit
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

    nlp_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] piv_reg, piv_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic          found_reg, found_next;
    nlp_pkg::emit_t emit_reg, emit_next;
    logic signed [nlp_pkg::DATA_W-1:0] cur_reg, cur_next;
    logic signed [nlp_pkg::DATA_W-1:0] piv_val_reg, piv_val_next;
    logic signed [nlp_pkg::DATA_W-1:0] tmp_reg, tmp_next;

    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;
    logic [AW-1:0] lo_inc;
    logic [AW-1:0] hi_dec;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign lo_inc   = lo_reg + AW'(1);
    assign hi_dec   = hi_reg - AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nlp_pkg::S_IDLE;
            count_reg <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        piv_reg     <= piv_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        found_reg   <= found_next;
        cur_reg     <= cur_next;
        piv_val_reg <= piv_val_next;
        tmp_reg     <= tmp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        piv_next     = piv_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        found_next   = found_reg;
        cur_next     = cur_reg;
        piv_val_next = piv_val_reg;
        tmp_next     = tmp_reg;
        emit_next    = '0;
        mem_req      = '0;
        busy         = (state_reg != nlp_pkg::S_IDLE);

        unique case (state_reg)
            nlp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        nlp_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        nlp_pkg::ACT_APPEND:
                        begin
                            if (count_reg < MAX_CNT)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = nlp_pkg::POS_W'(count_reg[AW-1:0]);
                                mem_req.wdata = cmd.value;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        nlp_pkg::ACT_ADVANCE:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_next.valid = 1'b1;
                                emit_next.zero  = 1'b1;
                                emit_next.last  = 1'b1;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                found_next = 1'b0;
                                ptr_next   = '0;
                                state_next = nlp_pkg::S_EMIT;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = nlp_pkg::POS_W'(count_m1[AW-1:0]);
                                ptr_next      = count_m2[AW-1:0];
                                state_next    = nlp_pkg::S_SCAN_FIRST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            nlp_pkg::S_SCAN_FIRST:
            begin
                cur_next      = rdata;
                mem_req.re    = 1'b1;
                mem_req.raddr = nlp_pkg::POS_W'(ptr_reg);
                state_next    = nlp_pkg::S_SCAN;
            end
            nlp_pkg::S_SCAN:
            begin
                if (rdata < cur_reg)
                begin
                    piv_next      = ptr_reg;
                    piv_val_next  = rdata;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = nlp_pkg::POS_W'(count_m1[AW-1:0]);
                    ptr_next      = count_m1[AW-1:0];
                    state_next    = nlp_pkg::S_FIND;
                end
                else if (ptr_reg == '0)
                begin
                    found_next = 1'b0;
                    state_next = nlp_pkg::S_EMIT;
                end
                else
                begin
                    cur_next      = rdata;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = nlp_pkg::POS_W'(ptr_reg - AW'(1));
                    ptr_next      = ptr_reg - AW'(1);
                end
            end
            nlp_pkg::S_FIND:
            begin
                if (rdata > piv_val_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = nlp_pkg::POS_W'(piv_reg);
                    mem_req.wdata = rdata;
                    state_next    = nlp_pkg::S_SWAP;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = nlp_pkg::POS_W'(ptr_reg - AW'(1));
                    ptr_next      = ptr_reg - AW'(1);
                end
            end
            nlp_pkg::S_SWAP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = nlp_pkg::POS_W'(ptr_reg);
                mem_req.wdata = piv_val_reg;
                found_next    = 1'b1;
                lo_next       = piv_reg + AW'(1);
                hi_next       = count_m1[AW-1:0];
                if ((piv_reg + AW'(1)) < count_m1[AW-1:0])
                begin
                    state_next = nlp_pkg::S_REV_LO;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = nlp_pkg::S_EMIT;
                end
            end
            nlp_pkg::S_REV_LO:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = nlp_pkg::POS_W'(lo_reg);
                state_next    = nlp_pkg::S_REV_HI;
            end
            nlp_pkg::S_REV_HI:
            begin
                tmp_next      = rdata;
                mem_req.re    = 1'b1;
                mem_req.raddr = nlp_pkg::POS_W'(hi_reg);
                state_next    = nlp_pkg::S_REV_WR_LO;
            end
            nlp_pkg::S_REV_WR_LO:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = nlp_pkg::POS_W'(lo_reg);
                mem_req.wdata = rdata;
                state_next    = nlp_pkg::S_REV_WR_HI;
            end
            nlp_pkg::S_REV_WR_HI:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = nlp_pkg::POS_W'(hi_reg);
                mem_req.wdata = tmp_reg;
                lo_next       = lo_inc;
                hi_next       = hi_dec;
                if (lo_inc < hi_dec)
                begin
                    state_next = nlp_pkg::S_REV_LO;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = nlp_pkg::S_EMIT;
                end
            end
            nlp_pkg::S_EMIT:
            begin
                mem_req.re         = 1'b1;
                mem_req.raddr      = nlp_pkg::POS_W'(ptr_reg);
                emit_next.valid    = 1'b1;
                emit_next.found    = found_reg;
                emit_next.position = nlp_pkg::POS_W'(ptr_reg);
                if (ptr_reg == count_m1[AW-1:0])
                begin
                    emit_next.last = 1'b1;
                    state_next     = nlp_pkg::S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = nlp_pkg::S_IDLE;
            end
        endcase
    end

    assign emit = emit_reg;

endmodule

FILE: hdl/next_lexicographic_permutation_core.sv
// top level of the next lexicographic permutation core
// depends on nlp_pkg, nlp_mem and nlp_seq
//
// channel   direction  handshake                     payload
// command   in         start high, busy low          cmd (nlp_pkg::cmd_t)
// result    out        result_strobe, one cycle      result (nlp_pkg::res_t)
//
// clear and append leave the sequencer idle and can follow back to back.
// an advance over n elements scans for the pivot, finds and writes its
// successor, finishes the swap, reverses the suffix pair by pair (read low,
// read high, write low, write high), then gives n result beats, one a cycle,
// through the emit state and result register; the single read port sets this.
// reset clears the element count; store contents stay undefined until appended.
// results cannot be stalled: each beat is shown for exactly one cycle.

module next_lexicographic_permutation_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  nlp_pkg::cmd_t  cmd,
    output logic           result_strobe,
    output nlp_pkg::res_t  result
);

    nlp_pkg::mem_req_t mem_req;
    nlp_pkg::emit_t    emit;
    logic signed [nlp_pkg::DATA_W-1:0] rdata;

    nlp_mem #(
        .DEPTH (MAX_ELEMENTS)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    nlp_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .rdata   (rdata),
        .mem_req (mem_req),
        .emit    (emit)
    );

    // empty array beat carries a zero element
    always_comb
    begin
        result.element   = emit.zero ? '0 : rdata;
        result.position  = emit.position;
        result.found     = emit.found;
        result.final_res = emit.last;
    end

    assign result_strobe = emit.valid;

    a_last_beat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.final_res && !(start && !busy)) |=> !result_strobe)
        else $error("beat after the final beat of an advance");

    a_beats_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.final_res) |=>
        (result_strobe &&
         result.position == nlp_pkg::POS_W'($past(result.position) + 6'd1)))
        else $error("result beats not contiguous in position");

    a_found_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.final_res) |=> (result.found == $past(result.found)))
        else $error("found flag changed within one advance");

    a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.final_res) |-> busy)
        else $error("command port free while result beats remain");

endmodule

FILE: tb/tb_top.sv
// testbench for next_lexicographic_permutation_core: directed and random command beats
// checked against an in-bench permutation predictor; depends on nlp_pkg and the core

module tb_top;

    localparam int MAX_ELEMENTS = 64;
    localparam int RANDOM_ITEMS = 205;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic [nlp_pkg::ACT_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [nlp_pkg::DATA_W-1:0] INT_MIN    = 32'h8000_0000;
    localparam logic [nlp_pkg::DATA_W-1:0] INT_MAX    = 32'h7fff_ffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    nlp_pkg::cmd_t cmd = '0;
    logic result_strobe;
    nlp_pkg::res_t result;

    nlp_pkg::cmd_t                     cmd_backlog[$];
    nlp_pkg::res_t                     due_beats[$];
    logic signed [nlp_pkg::DATA_W-1:0] perm_store [MAX_ELEMENTS];
    int                                perm_count = 0;
    logic                              cmd_taken = 1'b0;
    int                                burst_left = 1;
    int                                gap_left = 0;
    int                                mismatch_count = 0;
    int                                cycle_count = 0;
    int                                planned_count = 0;
    int                                issued_count = 0;

    next_lexicographic_permutation_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- stimulus

    task automatic queue_cmd(input logic [nlp_pkg::ACT_W-1:0] action,
                             input logic [nlp_pkg::DATA_W-1:0] value);
        nlp_pkg::cmd_t c;
        c.action = action;
        c.value  = value;
        cmd_backlog.push_back(c);
        case (action)
            nlp_pkg::ACT_CLEAR:
            begin
                planned_count = 0;
                issued_count++;
            end
            nlp_pkg::ACT_APPEND:
            begin
                if (planned_count < MAX_ELEMENTS)
                begin
                    planned_count++;
                    issued_count++;
                end
            end
            nlp_pkg::ACT_ADVANCE:
            begin
                issued_count++;
            end
            default:
            begin
            end
        endcase
    endtask

    // small values give repeated elements, the rest spans the whole range
    function automatic logic [nlp_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(0, 6) - 3;
            2:       return $urandom;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return INT_MIN;
                    1:       return INT_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic logic step_perm(int n);
        int                                i;
        int                                j;
        logic signed [nlp_pkg::DATA_W-1:0] t;
        if (n == 0)
        begin
            return 1'b0;
        end
        i = n - 1;
        while (i > 0 && perm_store[i-1] >= perm_store[i])
            i--;
        if (i == 0)
        begin
            return 1'b0;
        end
        j = n - 1;
        while (perm_store[j] <= perm_store[i-1])
            j--;
        t               = perm_store[i-1];
        perm_store[i-1] = perm_store[j];
        perm_store[j]   = t;
        j = n - 1;
        while (i < j)
        begin
            t             = perm_store[i];
            perm_store[i] = perm_store[j];
            perm_store[j] = t;
            i++;
            j--;
        end
        return 1'b1;
    endfunction

    task automatic apply_command(input nlp_pkg::cmd_t c);
        nlp_pkg::res_t beat;
        logic          found;
        case (c.action)
            nlp_pkg::ACT_CLEAR:
            begin
                perm_count = 0;
            end
            nlp_pkg::ACT_APPEND:
            begin
                if (perm_count < MAX_ELEMENTS)
                begin
                    perm_store[perm_count] = c.value;
                    perm_count++;
                end
            end
            nlp_pkg::ACT_ADVANCE:
            begin
                if (perm_count == 0)
                begin
                    beat           = '0;
                    beat.final_res = 1'b1;
                    due_beats.push_back(beat);
                end
                else
                begin
                    found = step_perm(perm_count);
                    for (int k = 0; k < perm_count; k++)
                    begin
                        beat.element   = perm_store[k];
                        beat.position  = nlp_pkg::POS_W'(k);
                        beat.found     = found;
                        beat.final_res = (k == perm_count - 1);
                        due_beats.push_back(beat);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name,
                               input logic signed [nlp_pkg::DATA_W-1:0] want,
                               input logic signed [nlp_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk)
    begin
        logic          next_start;
        nlp_pkg::cmd_t next_cmd;
        next_start = start;
        next_cmd   = cmd;
        if (rst_n && (!start || cmd_taken))
        begin
            next_start = 1'b0;
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (cmd_backlog.size() != 0)
            begin
                next_cmd   = cmd_backlog.pop_front();
                next_start = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                             : $urandom_range(0, 3);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
        start <= next_start;
        cmd   <= next_cmd;
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin
        nlp_pkg::res_t want;
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
        end
        else
        begin
            cmd_taken <= start && !busy;
            if (start && !busy)
            begin
                apply_command(cmd);
            end
            if (result_strobe)
            begin
                if (due_beats.size() == 0)
                begin
                    $error("result beat with none due: element %0d position %0d",
                           result.element, result.position);
                    mismatch_count++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    check_field("element", want.element, result.element);
                    check_field("position", nlp_pkg::DATA_W'(want.position),
                                nlp_pkg::DATA_W'(result.position));
                    check_field("found", nlp_pkg::DATA_W'(want.found),
                                nlp_pkg::DATA_W'(result.found));
                    check_field("final_res", nlp_pkg::DATA_W'(want.final_res),
                                nlp_pkg::DATA_W'(result.final_res));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int   base;
        int   len;
        logic full_done;
        full_done = 1'b0;

        // empty array, single element, extremes, duplicates, unused action
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_APPEND, INT_MIN);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_APPEND, INT_MAX);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(ACT_UNUSED, '1);
        queue_cmd(nlp_pkg::ACT_APPEND, '0);
        queue_cmd(nlp_pkg::ACT_APPEND, '1);
        queue_cmd(nlp_pkg::ACT_ADVANCE, '0);
        queue_cmd(nlp_pkg::ACT_CLEAR, '0);
        queue_cmd(nlp_pkg::ACT_ADVANCE, '1);
        queue_cmd(nlp_pkg::ACT_APPEND, 32'd1);
        queue_cmd(nlp_pkg::ACT_APPEND, 32'd1);
        queue_cmd(nlp_pkg::ACT_APPEND, 32'd2);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
        queue_cmd(nlp_pkg::ACT_CLEAR, '1);
        queue_cmd(ACT_UNUSED, '0);

        // mostly clear, fill, advance runs; some noise and missing clears
        base = issued_count;
        while (issued_count - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_cmd(nlp_pkg::ACT_W'($urandom_range(0, 3)), $urandom);
            end
            else
            begin
                if ($urandom_range(0, 5) != 0)
                begin
                    queue_cmd(nlp_pkg::ACT_CLEAR, $urandom);
                end
                if (!full_done && (issued_count - base > 120 || $urandom_range(0, 39) == 0))
                begin
                    len       = MAX_ELEMENTS + $urandom_range(1, 3);
                    full_done = 1'b1;
                end
                else
                begin
                    len = $urandom_range(1, 7);
                end
                repeat (len)
                    queue_cmd(nlp_pkg::ACT_APPEND, pick_value());
                repeat ($urandom_range(1, 5))
                    queue_cmd(nlp_pkg::ACT_ADVANCE, $urandom);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (cmd_backlog.size() != 0 || start || due_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
